// ===== rtl/core/vrp_pkg.sv =====
package vrp_pkg;

    // Field widths of the request and response items
    localparam int COORD_W  = 5;
    localparam int ORIGIN_W = 13;
    localparam int DIR_W    = 16;
    localparam int REACH_W  = 5;
    localparam int AXIS_W   = 2;

    localparam logic [REACH_W-1:0] REACH_RST = 5'd10;

    // Sum of squares of three directions, its 2^16 scaling, and the root
    localparam int SUMSQ_W  = 32;
    localparam int SQ_IN_W  = 48;
    localparam int ROOT_W   = 24;

    // Step limit 3*max_reach+3 fits in this width
    localparam int LIM_W    = 7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUMSQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_STEP,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] hit_x;
        logic [COORD_W-1:0] hit_y;
        logic [COORD_W-1:0] hit_z;
        logic [AXIS_W-1:0]  normal_axis;
        logic               normal_negative;
    } t_result;

endpackage

// ===== rtl/core/vrp_ifs.sv =====
interface vrp_req_if import vrp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [COORD_W-1:0]         voxel_x;
    logic [COORD_W-1:0]         voxel_y;
    logic [COORD_W-1:0]         voxel_z;
    logic                       solid;
    logic [ORIGIN_W-1:0]        origin_x;
    logic [ORIGIN_W-1:0]        origin_y;
    logic [ORIGIN_W-1:0]        origin_z;
    logic signed [DIR_W-1:0]    dir_x;
    logic signed [DIR_W-1:0]    dir_y;
    logic signed [DIR_W-1:0]    dir_z;

    modport source (
        output valid, action, voxel_x, voxel_y, voxel_z, solid,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );
    modport sink (
        input  valid, action, voxel_x, voxel_y, voxel_z, solid,
               origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

interface vrp_rsp_if import vrp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [COORD_W-1:0] hit_x;
    logic [COORD_W-1:0] hit_y;
    logic [COORD_W-1:0] hit_z;
    logic [AXIS_W-1:0]  normal_axis;
    logic               normal_negative;

    modport source (
        output valid, hit, hit_x, hit_y, hit_z, normal_axis, normal_negative,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_x, hit_y, hit_z, normal_axis, normal_negative,
        output ready
    );
endinterface

// ===== rtl/core/vrp_occ_mem.sv =====
module vrp_occ_mem #(
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic              i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic              o_rdata,
    output logic              o_busy
);

    logic              mem [2**ADDR_W];
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_rdata;

    // Clearing pass after reset: one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ===== rtl/core/vrp_sqrt.sv =====
module vrp_sqrt import vrp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_IN_W-1:0] i_val,
    output logic               o_done,
    output logic [ROOT_W-1:0]  o_root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SQ_IN_W-1:0] r_v;
    logic [SQ_IN_W-1:0] r_res;
    logic [SQ_IN_W-1:0] r_bit;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [SQ_IN_W:0]   trial;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};

    // Control: count one result bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(ROOT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end else if (r_cnt != '0) begin
            if ({1'b0, r_v} >= trial) begin
                r_v   <= r_v - trial[SQ_IN_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

// ===== rtl/core/vrp_div.sv =====
module vrp_div #(
    parameter int QW = 13,
    parameter int DW = 39,
    parameter int VW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int CNT_W = $clog2(QW + 1);

    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dsh;
    logic [QW-1:0]    r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    // Control: one quotient bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsh <= DW'(i_divisor) << (QW - 1);
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/voxel_ray_pick_core.sv =====
// A write item goes into the map at its transfer. A cast runs the sum of squares, the root,
// one division per axis, the cross products and a walk of at most 3*max_reach+3 voxels
// before result valid, and then waits while the previous result is held.
// Throughput: one cast at a time, the next accepted in the cycle after its result is loaded;
// a voxel step has a step state and a check state for the map read. Writes 1 per cycle
// while ready. Reset: synchronous, active low; max_reach returns to 10 and the occupancy
// map, 2^(3*GRID_BITS) entries (32768 at defaults), is cleared with ready low meanwhile.
module voxel_ray_pick_core import vrp_pkg::*; #(
    parameter int GRID_BITS = 5,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [REACH_W-1:0] i_cfg_data,
    vrp_req_if.sink            i_req,
    vrp_rsp_if.source          o_rsp
);

    // Origin, step distance, segment magnitude, product and coordinate widths.
    // Distances grow by one voxel per step, at most LIM_W bits of steps.
    localparam int OW = GRID_BITS + FRAC_BITS;
    localparam int NW = FRAC_BITS + LIM_W;
    localparam int MW = FRAC_BITS + REACH_W;
    localparam int PW = NW + MW;
    localparam int CW = GRID_BITS + 8;
    localparam int SW = CW + FRAC_BITS;
    localparam int AW = 3 * GRID_BITS;
    // Divider: dividend is 2*|d|*reach*2^(F+8) + len, divisor is 2*len
    localparam int DW = FRAC_BITS + 31;
    localparam int VW = ROOT_W + 1;
    localparam int ADR_W = DIR_W + REACH_W;

    t_state r_state, n_state;

    logic [REACH_W-1:0]      r_reach;
    logic [2:0]              r_k;
    logic [LIM_W-1:0]        r_steps;
    logic                    r_out_valid;
    t_result                 r_out;
    t_result                 r_res;

    logic [OW-1:0]           r_org [3];
    logic signed [DIR_W-1:0] r_dir [3];
    logic [SUMSQ_W-1:0]      r_s;
    logic [ROOT_W-1:0]       r_len;
    logic [MW-1:0]           r_mg  [3];
    logic                    r_neg [3];
    logic [NW-1:0]           r_nd  [3];
    logic signed [CW-1:0]    r_c   [3];
    logic signed [CW-1:0]    r_e   [3];
    logic [PW-1:0]           r_p   [6];
    logic [AXIS_W-1:0]       r_ax;
    logic                    r_inb;

    logic acc, cast_acc, wr_acc;
    logic out_free;

    // ---------------------------------------------------------------
    // Occupancy map
    // ---------------------------------------------------------------
    logic          mem_busy;
    logic          mem_rdata;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    assign acc      = i_req.valid && i_req.ready;
    assign cast_acc = acc && (i_req.action == ACT_CAST);
    assign wr_acc   = acc && (i_req.action == ACT_WRITE);

    // Drop index bits above the grid size
    assign mem_waddr = {GRID_BITS'(i_req.voxel_z), GRID_BITS'(i_req.voxel_y),
                        GRID_BITS'(i_req.voxel_x)};

    vrp_occ_mem #(
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_acc),
        .i_waddr (mem_waddr),
        .i_wdata (i_req.solid),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    assign i_req.ready = (r_state == ST_IDLE) && !mem_busy;

    // ---------------------------------------------------------------
    // Length: sum of squares, one direction at a time, then bit-serial root
    // ---------------------------------------------------------------
    logic signed [2*DIR_W-1:0] sq;
    logic [SUMSQ_W-1:0]        n_s;
    logic                      sq_done;
    logic [ROOT_W-1:0]         sq_root;

    assign sq  = r_dir[r_k[1:0]] * r_dir[r_k[1:0]];
    assign n_s = r_s + SUMSQ_W'(unsigned'(sq));

    vrp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SQRT_GO),
        .i_val   ({r_s, 16'b0}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // ---------------------------------------------------------------
    // Segment components: one shared divider, one axis after another
    // ---------------------------------------------------------------
    logic signed [DIR_W-1:0] cur_dir;
    logic [OW-1:0]           cur_org;
    logic [DIR_W-1:0]        ad;
    logic [ADR_W-1:0]        adr;
    logic [DW-1:0]           dividend;
    logic                    dv_done;
    logic [MW-1:0]           dv_quot;
    logic                    dneg;
    logic signed [SW-1:0]    o_s, q_s, e_sum;
    logic signed [CW-1:0]    e0, cs;
    logic [NW-1:0]           nd0;

    assign cur_dir  = r_dir[r_k[1:0]];
    assign cur_org  = r_org[r_k[1:0]];
    assign ad       = cur_dir[DIR_W-1] ? DIR_W'(-cur_dir) : DIR_W'(cur_dir);
    assign adr      = ADR_W'(ad) * ADR_W'(r_reach);
    assign dividend = (DW'(adr) << (FRAC_BITS + 9)) + DW'(r_len);

    vrp_div #(
        .QW (MW),
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIV_GO),
        .i_dividend (dividend),
        .i_divisor  ({r_len, 1'b0}),
        .o_done     (dv_done),
        .o_quot     (dv_quot)
    );

    // Step direction is minus only for a negative, nonzero component
    assign dneg  = cur_dir[DIR_W-1] && (dv_quot != '0);
    assign o_s   = $signed(SW'(cur_org));
    assign q_s   = $signed(SW'(dv_quot));
    assign e_sum = dneg ? (o_s - q_s) : (o_s + q_s);
    assign e0    = CW'(e_sum >>> FRAC_BITS);
    assign cs    = $signed(CW'(cur_org >> FRAC_BITS));
    // Distance to the next boundary; an origin on a boundary going down gives zero
    assign nd0   = dneg ? NW'(cur_org[FRAC_BITS-1:0])
                        : (NW'(1) << FRAC_BITS) - NW'(cur_org[FRAC_BITS-1:0]);

    // ---------------------------------------------------------------
    // Cross products nd[i]*mg[j], one per cycle; kept up by adds in the walk.
    // Order: 01 02 10 12 20 21
    // ---------------------------------------------------------------
    logic [NW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] prod;

    always_comb begin
        case (r_k)
            3'd0:    begin mul_a = r_nd[0]; mul_b = r_mg[1]; end
            3'd1:    begin mul_a = r_nd[0]; mul_b = r_mg[2]; end
            3'd2:    begin mul_a = r_nd[1]; mul_b = r_mg[0]; end
            3'd3:    begin mul_a = r_nd[1]; mul_b = r_mg[2]; end
            3'd4:    begin mul_a = r_nd[2]; mul_b = r_mg[0]; end
            3'd5:    begin mul_a = r_nd[2]; mul_b = r_mg[1]; end
            default: begin mul_a = '0;      mul_b = '0;      end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    // ---------------------------------------------------------------
    // Walk: pick the axis with the earliest boundary, step, read the map
    // ---------------------------------------------------------------
    logic                 e01, e02, e12;
    logic [AXIS_W-1:0]    ax_sel;
    logic signed [CW-1:0] n_c [3];
    logic                 n_inb;
    logic                 at_end, at_limit, walk_stop;
    logic [LIM_W-1:0]     limit;
    logic [PW-1:0]        mgf [3];

    assign e01 = (r_mg[0] == '0) ? 1'b0 : (r_mg[1] == '0) ? 1'b1 : (r_p[0] < r_p[2]);
    assign e02 = (r_mg[0] == '0) ? 1'b0 : (r_mg[2] == '0) ? 1'b1 : (r_p[1] < r_p[4]);
    assign e12 = (r_mg[1] == '0) ? 1'b0 : (r_mg[2] == '0) ? 1'b1 : (r_p[3] < r_p[5]);

    // X only when strictly first; Y beats X on ties; Z beats Y on ties
    assign ax_sel = e01 ? (e02 ? AXIS_X : AXIS_Z) : (e12 ? AXIS_Y : AXIS_Z);

    assign limit     = LIM_W'(3 * LIM_W'(r_reach)) + LIM_W'(3);
    assign at_end    = (r_c[0] == r_e[0]) && (r_c[1] == r_e[1]) && (r_c[2] == r_e[2]);
    assign at_limit  = (r_steps >= limit);
    assign walk_stop = at_end || at_limit;

    always_comb begin
        n_inb = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mgf[i] = PW'(r_mg[i]) << FRAC_BITS;
            if (ax_sel == AXIS_W'(i)) begin
                n_c[i] = r_neg[i] ? (r_c[i] - 1'b1) : (r_c[i] + 1'b1);
            end else begin
                n_c[i] = r_c[i];
            end
            // Outside the grid reads as empty
            if (n_c[i][CW-1:GRID_BITS] != '0) begin
                n_inb = 1'b0;
            end
        end
    end

    assign mem_raddr = {n_c[2][GRID_BITS-1:0], n_c[1][GRID_BITS-1:0],
                        n_c[0][GRID_BITS-1:0]};

    // Face normal of the voxel just entered
    logic [OW-1:0]        nrm_org;
    logic signed [CW-1:0] nrm_c;
    logic                 nrm_neg;

    always_comb begin
        case (r_ax)
            AXIS_X:  begin nrm_org = r_org[0]; nrm_c = r_c[0]; end
            AXIS_Y:  begin nrm_org = r_org[1]; nrm_c = r_c[1]; end
            AXIS_Z:  begin nrm_org = r_org[2]; nrm_c = r_c[2]; end
            default: begin nrm_org = '0;       nrm_c = '0;     end
        endcase
    end

    assign nrm_neg = $signed(SW'(nrm_org)) < $signed({nrm_c, {FRAC_BITS{1'b0}}});

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    assign out_free = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cast_acc) begin
                    n_state = ST_SUMSQ;
                end
            end
            ST_SUMSQ: begin
                if (r_k == 3'd2) begin
                    // All-zero direction yields an all-zero result
                    n_state = (n_s == '0) ? ST_DONE : ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                n_state = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sq_done) begin
                    n_state = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (dv_done) begin
                    n_state = (r_k == 3'd2) ? ST_MUL : ST_DIV_GO;
                end
            end
            ST_MUL: begin
                if (r_k == 3'd5) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = walk_stop ? ST_DONE : ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (r_inb && mem_rdata) ? ST_DONE : ST_STEP;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control counters, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach     <= REACH_RST;
            r_k         <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_reach <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE:      r_k <= '0;
                ST_SUMSQ:     r_k <= (r_k == 3'd2) ? 3'd0 : r_k + 3'd1;
                ST_SQRT_WAIT: r_k <= '0;
                ST_DIV_WAIT: begin
                    if (dv_done) begin
                        r_k <= (r_k == 3'd2) ? 3'd0 : r_k + 3'd1;
                    end
                end
                ST_MUL: begin
                    r_k     <= r_k + 3'd1;
                    r_steps <= '0;
                end
                ST_STEP: begin
                    if (!walk_stop) begin
                        r_steps <= r_steps + 1'b1;
                    end
                end
                default: begin
                end
            endcase
            // Hold the result until the transfer; load the next one behind it
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (cast_acc) begin
                    r_org[0] <= OW'(i_req.origin_x);
                    r_org[1] <= OW'(i_req.origin_y);
                    r_org[2] <= OW'(i_req.origin_z);
                    r_dir[0] <= i_req.dir_x;
                    r_dir[1] <= i_req.dir_y;
                    r_dir[2] <= i_req.dir_z;
                    r_s      <= '0;
                end
            end
            ST_SUMSQ: begin
                r_s <= n_s;
                if (r_k == 3'd2) begin
                    r_res <= '0;
                end
            end
            ST_SQRT_WAIT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                end
            end
            ST_DIV_WAIT: begin
                if (dv_done) begin
                    r_mg[r_k[1:0]]  <= dv_quot;
                    r_neg[r_k[1:0]] <= dneg;
                    r_nd[r_k[1:0]]  <= nd0;
                    r_c[r_k[1:0]]   <= cs;
                    r_e[r_k[1:0]]   <= e0;
                end
            end
            ST_MUL: begin
                r_p[r_k] <= prod;
            end
            ST_STEP: begin
                if (walk_stop) begin
                    r_res <= '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        r_c[i] <= n_c[i];
                    end
                    // Advance the taken axis's distance by one voxel in both of its cross products
                    case (ax_sel)
                        AXIS_X: begin
                            r_p[0] <= r_p[0] + mgf[1];
                            r_p[1] <= r_p[1] + mgf[2];
                        end
                        AXIS_Y: begin
                            r_p[2] <= r_p[2] + mgf[0];
                            r_p[3] <= r_p[3] + mgf[2];
                        end
                        default: begin
                            r_p[4] <= r_p[4] + mgf[0];
                            r_p[5] <= r_p[5] + mgf[1];
                        end
                    endcase
                    r_ax  <= ax_sel;
                    r_inb <= n_inb;
                end
            end
            ST_CHECK: begin
                if (r_inb && mem_rdata) begin
                    r_res.hit             <= 1'b1;
                    r_res.hit_x           <= COORD_W'(r_c[0][GRID_BITS-1:0]);
                    r_res.hit_y           <= COORD_W'(r_c[1][GRID_BITS-1:0]);
                    r_res.hit_z           <= COORD_W'(r_c[2][GRID_BITS-1:0]);
                    r_res.normal_axis     <= r_ax;
                    r_res.normal_negative <= nrm_neg;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hit             = r_out.hit;
    assign o_rsp.hit_x           = r_out.hit_x;
    assign o_rsp.hit_y           = r_out.hit_y;
    assign o_rsp.hit_z           = r_out.hit_z;
    assign o_rsp.normal_axis     = r_out.normal_axis;
    assign o_rsp.normal_negative = r_out.normal_negative;

endmodule

// ===== rtl/core/vrp_checker.sv =====
module vrp_checker import vrp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_req_action,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input logic               i_rsp_hit,
    input logic [COORD_W-1:0] i_rsp_hit_x,
    input logic [COORD_W-1:0] i_rsp_hit_y,
    input logic [COORD_W-1:0] i_rsp_hit_z,
    input logic [AXIS_W-1:0]  i_rsp_normal_axis,
    input logic               i_rsp_normal_negative
);

    // A stalled response holds its hit, hit_x and normal axis
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hit)
            && $stable(i_rsp_hit_x) && $stable(i_rsp_normal_axis))
        else $error("response changed while stalled");

    // A miss reports all fields zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_hit |-> i_rsp_hit_x == '0 && i_rsp_hit_y == '0
            && i_rsp_hit_z == '0 && i_rsp_normal_axis == AXIS_X && !i_rsp_normal_negative)
        else $error("miss with nonzero fields");

    a_axis_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_normal_axis == AXIS_X || i_rsp_normal_axis == AXIS_Y
            || i_rsp_normal_axis == AXIS_Z)
        else $error("illegal normal axis");

    // Map clearing keeps the request side closed right after reset
    a_clear_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_req_ready)
        else $error("ready during map clear");

    // A cast occupies the block
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_action == ACT_CAST |=> !i_req_ready)
        else $error("ready right after a cast transfer");

endmodule

bind voxel_ray_pick_core vrp_checker u_vrp_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .i_req_action          (i_req.action),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_hit             (o_rsp.hit),
    .i_rsp_hit_x           (o_rsp.hit_x),
    .i_rsp_hit_y           (o_rsp.hit_y),
    .i_rsp_hit_z           (o_rsp.hit_z),
    .i_rsp_normal_axis     (o_rsp.normal_axis),
    .i_rsp_normal_negative (o_rsp.normal_negative)
);

// ===== sim/voxel_ray_pick_core_tb.sv =====
module voxel_ray_pick_core_tb import vrp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_BITS  = 5;
    localparam int FRAC_BITS  = 8;
    localparam int GRID_N     = 1 << GRID_BITS;
    localparam int ONE_FX     = 1 << FRAC_BITS;
    // Writes cannot be observed, so hold this long before any register write to let
    // a trailing write retire.
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic                    action;
        logic [COORD_W-1:0]      vx;
        logic [COORD_W-1:0]      vy;
        logic [COORD_W-1:0]      vz;
        logic                    solid;
        logic [ORIGIN_W-1:0]     ox;
        logic [ORIGIN_W-1:0]     oy;
        logic [ORIGIN_W-1:0]     oz;
        logic signed [DIR_W-1:0] dx;
        logic signed [DIR_W-1:0] dy;
        logic signed [DIR_W-1:0] dz;
    } t_item;

    // One row of the directed table: the item, and optionally a typed-in result
    typedef struct {
        t_item   item;
        bit      fixed;
        t_result want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [REACH_W-1:0]  i_cfg_data = '0;

    vrp_req_if req_if ();
    vrp_rsp_if rsp_if ();

    voxel_ray_pick_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's state
    bit              occ_map [GRID_N*GRID_N*GRID_N];
    int unsigned     reach_now = REACH_RST;

    t_result         pick_queue [$];
    int              n_fail = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;

    // ------------------------------------------------------------------
    // Predictor: exact integer Amanatides-Woo walk over the shadow map
    // ------------------------------------------------------------------
    function automatic bit solid_at(longint x, longint y, longint z);
        if (x < 0 || y < 0 || z < 0 || x >= GRID_N || y >= GRID_N || z >= GRID_N)
            return 1'b0;
        return occ_map[(z << (2*GRID_BITS)) | (y << GRID_BITS) | x];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // Axis i crosses its next boundary strictly before axis j
    function automatic bit crosses_first(longint ni, longint mi, longint nj, longint mj);
        if (mi == 0) return 1'b0;
        if (mj == 0) return 1'b1;
        return ni * mj < nj * mi;
    endfunction

    function automatic t_result trace_ray(t_item it);
        t_result         res;
        longint          org [3];
        longint          dir [3];
        longint          cur [3];
        longint          fin [3];
        longint          stp [3];
        longint          mag [3];
        longint          nxt [3];
        longint          seg;
        longint unsigned sumsq, len, num;
        int unsigned     lim, steps;
        int              ax;
        res = '0;
        org[0] = it.ox; org[1] = it.oy; org[2] = it.oz;
        dir[0] = it.dx; dir[1] = it.dy; dir[2] = it.dz;
        sumsq = 0;
        for (int k = 0; k < 3; k++) sumsq += dir[k] * dir[k];
        if (sumsq == 0) return res;
        len = int_sqrt(sumsq << 16);
        for (int k = 0; k < 3; k++) begin
            num = (dir[k] < 0 ? -dir[k] : dir[k]) * reach_now * ONE_FX * 256;
            seg = (2 * num + len) / (2 * len);
            if (dir[k] < 0) seg = -seg;
            cur[k] = org[k] >>> FRAC_BITS;
            fin[k] = (org[k] + seg) >>> FRAC_BITS;   // arithmetic shift floors
            stp[k] = (seg >= 0) ? 1 : -1;
            mag[k] = (seg < 0) ? -seg : seg;
            nxt[k] = (stp[k] > 0) ? (cur[k] + 1) * ONE_FX - org[k]
                                  : org[k] - cur[k] * ONE_FX;
        end
        lim = 3 * reach_now + 3;
        steps = 0;
        while ((cur[0] != fin[0] || cur[1] != fin[1] || cur[2] != fin[2]) && steps < lim) begin
            if (crosses_first(nxt[0], mag[0], nxt[1], mag[1]))
                ax = crosses_first(nxt[0], mag[0], nxt[2], mag[2]) ? 0 : 2;
            else
                ax = crosses_first(nxt[1], mag[1], nxt[2], mag[2]) ? 1 : 2;
            cur[ax] += stp[ax];
            nxt[ax] += ONE_FX;
            steps++;
            if (solid_at(cur[0], cur[1], cur[2])) begin
                res.hit             = 1'b1;
                res.hit_x           = cur[0][COORD_W-1:0];
                res.hit_y           = cur[1][COORD_W-1:0];
                res.hit_z           = cur[2][COORD_W-1:0];
                res.normal_axis     = ax[AXIS_W-1:0];
                res.normal_negative = org[ax] < cur[ax] * ONE_FX;
                return res;
            end
        end
        return res;
    endfunction

    // Apply an accepted item to the shadow state and queue its pick, if any
    task automatic predict_item(t_item it, bit fixed, t_result want);
        if (it.action == ACT_WRITE) begin
            occ_map[{it.vz, it.vy, it.vx}] = it.solid;
        end else begin
            pick_queue.push_back(fixed ? want : trace_ray(it));
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    initial begin
        req_if.valid    = 1'b0;
        req_if.action   = ACT_WRITE;
        req_if.voxel_x  = '0;
        req_if.voxel_y  = '0;
        req_if.voxel_z  = '0;
        req_if.solid    = 1'b0;
        req_if.origin_x = '0;
        req_if.origin_y = '0;
        req_if.origin_z = '0;
        req_if.dir_x    = '0;
        req_if.dir_y    = '0;
        req_if.dir_z    = '0;
        rsp_if.ready    = 1'b0;
    end

    // Drive one item and hold it until the transfer; apply random sender gaps.
    // Valid stays high after the transfer so the next item can follow back to back.
    task automatic send_item(t_item it, bit fixed, t_result want);
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.action   <= it.action;
        req_if.voxel_x  <= it.vx;
        req_if.voxel_y  <= it.vy;
        req_if.voxel_z  <= it.vz;
        req_if.solid    <= it.solid;
        req_if.origin_x <= it.ox;
        req_if.origin_y <= it.oy;
        req_if.origin_z <= it.oz;
        req_if.dir_x    <= it.dx;
        req_if.dir_y    <= it.dy;
        req_if.dir_z    <= it.dz;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predict_item(it, fixed, want);
    endtask

    // Wait for all picks, let a trailing write retire, then write max_reach
    task automatic set_reach(int unsigned val);
        req_if.valid <= 1'b0;
        while (pick_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val[REACH_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        reach_now  = val;
    endtask

    function automatic t_item wr_item(int x, int y, int z, bit s);
        t_item it = '0;
        it.action = ACT_WRITE;
        it.vx = COORD_W'(x); it.vy = COORD_W'(y); it.vz = COORD_W'(z); it.solid = s;
        return it;
    endfunction

    function automatic t_item cast_item(int ox, int oy, int oz, int dx, int dy, int dz);
        t_item it = '0;
        it.action = ACT_CAST;
        it.ox = ORIGIN_W'(ox); it.oy = ORIGIN_W'(oy); it.oz = ORIGIN_W'(oz);
        it.dx = DIR_W'(dx); it.dy = DIR_W'(dy); it.dz = DIR_W'(dz);
        return it;
    endfunction

    // Random item; most are writes near a cast target or casts from random origins
    function automatic t_item rand_item();
        t_item it;
        it = t_item'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 45) begin
            it.action = ACT_WRITE;
            it.solid  = $urandom_range(99) < 80;
            if ($urandom_range(3) != 0) begin
                // cluster writes so casts actually hit something
                it.vx = COORD_W'(8 + $urandom_range(15));
                it.vy = COORD_W'(8 + $urandom_range(15));
                it.vz = COORD_W'(8 + $urandom_range(15));
            end
        end else begin
            it.action = ACT_CAST;
            case ($urandom_range(5))
                0: ;                                            // raw noise
                1: begin
                    it.dx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
                    it.dy = '0; it.dz = '0;
                    if ($urandom_range(1)) it.ox[FRAC_BITS-1:0] = '0;
                end
                2: begin
                    it.dx = DIR_W'($urandom_range(32768) - 16384);
                    it.dy = it.dx;
                    it.dz = $urandom_range(1) ? it.dx : -it.dx;
                end
                default: begin
                    it.ox = ORIGIN_W'((6 + $urandom_range(19)) * ONE_FX
                                      + $urandom_range(ONE_FX-1));
                    it.oy = ORIGIN_W'((6 + $urandom_range(19)) * ONE_FX
                                      + $urandom_range(ONE_FX-1));
                    it.oz = ORIGIN_W'((6 + $urandom_range(19)) * ONE_FX
                                      + $urandom_range(ONE_FX-1));
                    it.dx = DIR_W'($urandom_range(32768) - 16384);
                    it.dy = DIR_W'($urandom_range(32768) - 16384);
                    it.dz = DIR_W'($urandom_range(32768) - 16384);
                end
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Response side: random stalls, compare against the oldest pick
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pick_queue.size() == 0) begin
                    $error("unexpected result transfer");
                    n_fail++;
                end else begin
                    automatic t_result exp_r = pick_queue.pop_front();
                    if (rsp_if.hit !== exp_r.hit) begin
                        $error("hit: expected %0d actual %0d", exp_r.hit, rsp_if.hit);
                        n_fail++;
                    end
                    if (rsp_if.hit_x !== exp_r.hit_x) begin
                        $error("hit_x: expected %0d actual %0d", exp_r.hit_x, rsp_if.hit_x);
                        n_fail++;
                    end
                    if (rsp_if.hit_y !== exp_r.hit_y) begin
                        $error("hit_y: expected %0d actual %0d", exp_r.hit_y, rsp_if.hit_y);
                        n_fail++;
                    end
                    if (rsp_if.hit_z !== exp_r.hit_z) begin
                        $error("hit_z: expected %0d actual %0d", exp_r.hit_z, rsp_if.hit_z);
                        n_fail++;
                    end
                    if (rsp_if.normal_axis !== exp_r.normal_axis) begin
                        $error("normal_axis: expected %0d actual %0d",
                               exp_r.normal_axis, rsp_if.normal_axis);
                        n_fail++;
                    end
                    if (rsp_if.normal_negative !== exp_r.normal_negative) begin
                        $error("normal_negative: expected %0d actual %0d",
                               exp_r.normal_negative, rsp_if.normal_negative);
                        n_fail++;
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    t_row dir_rows [$];

    task automatic add_row(t_item it, bit fixed, t_result want);
        t_row r;
        r.item = it; r.fixed = fixed; r.want = want;
        dir_rows.push_back(r);
    endtask

    initial begin
        t_result none;
        t_result want;
        none = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Typed-in results only where obvious.
        // empty map after reset: no hit
        add_row(cast_item(16*ONE_FX+128, 16*ONE_FX+128, 16*ONE_FX+128, 16384, 0, 0), 1, none);
        // zero direction: every field zero
        add_row(cast_item(8191, 8191, 8191, 0, 0, 0), 1, none);
        // block one voxel ahead on +x and hit it through its -x face
        add_row(wr_item(17, 16, 16, 1), 0, none);
        want = '{1'b1, 5'd17, 5'd16, 5'd16, AXIS_X, 1'b1};
        add_row(cast_item(16*ONE_FX+128, 16*ONE_FX+128, 16*ONE_FX+128, 16384, 0, 0), 1, want);
        // same voxel from the other side, -x direction, positive normal
        want = '{1'b1, 5'd17, 5'd16, 5'd16, AXIS_X, 1'b0};
        add_row(cast_item(20*ONE_FX+128, 16*ONE_FX+128, 16*ONE_FX+128, -16384, 0, 0), 1, want);
        // on a boundary pointing down: enters the lower voxel first
        add_row(cast_item(18*ONE_FX, 16*ONE_FX+128, 16*ONE_FX+128, -16384, 0, 0), 0, none);
        // start voxel itself solid: not tested
        add_row(cast_item(17*ONE_FX+10, 16*ONE_FX+128, 16*ONE_FX+128, 0, 16384, 0), 0, none);
        // exact diagonals exercise the tie order
        add_row(wr_item(16, 17, 17, 1), 0, none);
        add_row(cast_item(16*ONE_FX+128, 16*ONE_FX+128, 16*ONE_FX+128, 16384, 16384, 16384), 0, none);
        add_row(cast_item(16*ONE_FX, 16*ONE_FX, 16*ONE_FX, -16384, -16384, -16384), 0, none);
        add_row(cast_item(0, 0, 0, 16384, 16384, 0), 0, none);
        // extremes of origin and direction, walk outside the grid
        add_row(cast_item(8191, 8191, 8191, 16384, 16384, 16384), 0, none);
        add_row(cast_item(0, 0, 0, -16384, -16384, -16384), 0, none);
        add_row(cast_item(0, 8191, 0, -32768, 32767, -1), 0, none);
        add_row(cast_item(8191, 0, 8191, 1, -1, 32767), 0, none);
        // corner voxels, written then cleared
        add_row(wr_item(31, 31, 31, 1), 0, none);
        add_row(cast_item(30*ONE_FX+128, 30*ONE_FX+128, 30*ONE_FX+128, 16384, 16384, 16384), 0, none);
        add_row(wr_item(0, 0, 0, 1), 0, none);
        add_row(cast_item(2*ONE_FX+5, 1*ONE_FX+9, 1*ONE_FX+200, -16384, -9000, -4000), 0, none);
        add_row(wr_item(31, 31, 31, 0), 0, none);
        add_row(wr_item(0, 0, 0, 0), 0, none);
        add_row(cast_item(2*ONE_FX+5, 1*ONE_FX+9, 1*ONE_FX+200, -16384, -9000, -4000), 0, none);

        for (int i = 0; i < dir_rows.size(); i++)
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

        // Random phases: vary idling and max_reach, extremes among them
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (ph)
                0: set_reach(31);
                1: set_reach(1);
                2: set_reach(0);
                3: set_reach(10);
                4: set_reach($urandom_range(2, 30));
                5: set_reach(31);
                6: set_reach($urandom_range(1, 31));
                default: set_reach(5);
            endcase
            for (int n = 0; n < 75; n++)
                send_item(rand_item(), 1'b0, none);
        end

        req_if.valid <= 1'b0;
        while (pick_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Reset clears 32768 voxels first; then ~620 items, some of them stalled
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
